// File: sv/tdsm_pkg.sv
// Shared types, codes and the segment lookup of the two-digit display mux.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package tdsm_pkg;

  localparam int ValueW   = 15;
  localparam int QuotW    = 12;
  localparam int SegW     = 7;
  localparam int LinesW   = 2;
  localparam int RecipW   = 16;
  localparam int RecipSh  = 19;

  // Reciprocal of ten, exact for any value below 81920 with a shift of 19.
  localparam logic [RecipW-1:0] RECIP_TEN = 16'hCCCD;
  localparam logic [ValueW-1:0] TWO_DIGIT_LIMIT = 15'd100;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [LinesW-1:0] LINES_RESET = 2'b01;
  localparam logic [SegW-1:0]   SEG_RESET   = 7'h00;
  localparam logic [SegW-1:0]   SEG_BLANK   = 7'h7F;

  typedef struct packed {
    logic              action;
    logic [ValueW-1:0] value;
  } item_t;

  typedef struct packed {
    logic [SegW-1:0]   segments_n;
    logic [LinesW-1:0] digit_lines;
  } disp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  // Stored patterns and busy flag handed from the digit unit to the top.
  typedef struct packed {
    logic            busy;
    logic [SegW-1:0] ones;
    logic [SegW-1:0] tens;
  } digits_t;

  function automatic logic [SegW-1:0] seg_of(input logic [3:0] digit);
    logic [SegW-1:0] pat;
    case (digit)
      4'd0:    pat = 7'h40;
      4'd1:    pat = 7'h79;
      4'd2:    pat = 7'h24;
      4'd3:    pat = 7'h30;
      4'd4:    pat = 7'h19;
      4'd5:    pat = 7'h12;
      4'd6:    pat = 7'h02;
      4'd7:    pat = 7'h78;
      4'd8:    pat = 7'h00;
      4'd9:    pat = 7'h18;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// File: sv/tdsm_div10.sv
// Divide-by-ten unit: quotient by reciprocal multiply, remainder by shift-add.
// Depends on tdsm_pkg.
`default_nettype none

module tdsm_div10 (
  input  wire logic [tdsm_pkg::ValueW-1:0] dividend,
  output logic      [tdsm_pkg::QuotW-1:0]  quot,
  output logic      [3:0]                  rem
);
  import tdsm_pkg::*;

  logic [ValueW+RecipW-1:0] prod;
  logic [ValueW-1:0]        quot_ext;
  logic [ValueW-1:0]        rem_full;

  assign prod     = {{RecipW{1'b0}}, dividend} * {{ValueW{1'b0}}, RECIP_TEN};
  assign quot     = prod[RecipSh+QuotW-1:RecipSh];
  assign quot_ext = {{(ValueW-QuotW){1'b0}}, quot};
  // rem = dividend - 8q - 2q
  assign rem_full = dividend - (quot_ext << 3) - (quot_ext << 1);
  assign rem      = rem_full[3:0];

endmodule

`default_nettype wire

// File: sv/tdsm_digits.sv
// Write sequencer: reduces a value until below 100 with the shared divide-by-ten
// unit, then stores both digit patterns. Depends on tdsm_pkg, tdsm_div10.
`default_nettype none

module tdsm_digits (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tdsm_pkg::ValueW-1:0] start_value,
  output tdsm_pkg::digits_t                status
);
  import tdsm_pkg::*;

  state_t            state;
  logic [ValueW-1:0] work;
  logic [SegW-1:0]   ones;
  logic [SegW-1:0]   tens;
  logic [QuotW-1:0]  quot;
  logic [3:0]        rem;

  tdsm_div10 u_div10 (
    .dividend (work),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ones  <= SEG_RESET;
      tens  <= SEG_RESET;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Two digits left: split and store, else drop the lowest digit.
          if (work < TWO_DIGIT_LIMIT) begin
            ones  <= seg_of(rem);
            tens  <= seg_of(quot[3:0]);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      work <= start_value;
    end else if (state == ST_DIV && work >= TWO_DIGIT_LIMIT) begin
      work <= {{(ValueW-QuotW){1'b0}}, quot};
    end
  end

  assign status.busy = (state != ST_IDLE);
  assign status.ones = ones;
  assign status.tens = tens;

endmodule

`default_nettype wire

// File: sv/two_digit_seven_segment_mux_unit.sv
// Top level of the two-digit seven-segment display mux.
// Depends on tdsm_pkg and tdsm_digits.
//
// Usage:
//   Input channel item/item_valid/item_stall carries an action and a value.
//   A write transfer (action = write) loads a new value; it gives no result.
//   The value is reduced by repeated divide-by-ten passes through one shared
//   reciprocal-multiply unit until below 100, then both digit patterns
//   (active low, bit0 = a .. bit6 = g) are stored. A write keeps the block
//   busy after its transfer for one pass per digit beyond two, plus the
//   final split; item_stall stays high meanwhile.
//   A tick transfer toggles both digit lines and yields one result on
//   disp/disp_valid/disp_stall in the next cycle: the ones pattern first
//   after reset, then tens, alternating, with the new lines.
//   The result sits in an output register; a new item is taken in the cycle
//   that register drains. While disp_stall holds a waiting result, the input
//   stalls and the result stays unchanged.
//   Reset (rst, synchronous): patterns read as all segments lit, tens line
//   high, ones digit is next to show, no result pending.
`default_nettype none

module two_digit_seven_segment_mux_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire tdsm_pkg::item_t item,
  output logic                 disp_valid,
  input  wire logic            disp_stall,
  output tdsm_pkg::disp_t      disp
);
  import tdsm_pkg::*;

  digits_t           status;
  logic              out_free;
  logic              take;
  logic              write_go;
  logic              tick_go;
  logic              show_ones;
  logic [LinesW-1:0] lines;

  // Output register is free when empty or being drained this cycle.
  assign out_free   = !disp_valid || !disp_stall;
  assign item_stall = status.busy || !out_free;
  assign take       = item_valid && !item_stall;
  assign write_go   = take && (item.action == ACT_WRITE);
  assign tick_go    = take && (item.action == ACT_TICK);

  tdsm_digits u_digits (
    .clk         (clk),
    .rst         (rst),
    .start       (write_go),
    .start_value (item.value),
    .status      (status)
  );

  // Line and turn state: toggle on every tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      show_ones <= 1'b1;
      lines     <= LINES_RESET;
    end else if (tick_go) begin
      show_ones <= !show_ones;
      lines     <= ~lines;
    end
  end

  // Output register: load on a tick, clear once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_valid <= 1'b0;
    end else if (tick_go) begin
      disp_valid <= 1'b1;
    end else if (!disp_stall) begin
      disp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      disp.segments_n  <= show_ones ? status.ones : status.tens;
      disp.digit_lines <= ~lines;
    end
  end

endmodule

`default_nettype wire

// File: sv/tdsm_check.sv
// Port-level checker for the two-digit display mux, bound to its top level.
// Depends on tdsm_pkg.
`default_nettype none

module tdsm_check (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            item_valid,
  input wire logic            item_stall,
  input wire tdsm_pkg::item_t item,
  input wire logic            disp_valid,
  input wire logic            disp_stall,
  input wire tdsm_pkg::disp_t disp
);
  import tdsm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    disp_valid && disp_stall |=> disp_valid && $stable(disp))
    else $error("stalled result changed or dropped");

  a_lines: assert property (@(posedge clk) disable iff (rst)
    disp_valid |-> (disp.digit_lines == 2'b01) || (disp.digit_lines == 2'b10))
    else $error("digit lines not exactly one active");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.action == ACT_WRITE |=> item_stall)
    else $error("write transfer did not hold off the next item");

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.action == ACT_TICK |=> disp_valid)
    else $error("tick transfer gave no result");

endmodule

bind two_digit_seven_segment_mux_unit tdsm_check u_tdsm_check (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .item       (item),
  .disp_valid (disp_valid),
  .disp_stall (disp_stall),
  .disp       (disp)
);

`default_nettype wire

// File: dv/tdsm_disp_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the two-digit seven-segment mux: tracks the display state,
// predicts each tick's display frame and compares the frames that come out.
// Depends on tdsm_pkg for the channel structs and the action codes.

module tdsm_disp_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  tdsm_pkg::item_t   item,
  input  logic              disp_valid,
  input  logic              disp_stall,
  input  tdsm_pkg::disp_t   disp,
  output int                fail_cnt,
  output int                pending_cnt
);
  import tdsm_pkg::*;

  // Active-low patterns for digits 9 down to 0, digit 0 in the low bits.
  localparam logic [10*SegW-1:0] DIGIT_SEG = {
    7'h18, 7'h00, 7'h78, 7'h02, 7'h12, 7'h19, 7'h30, 7'h24, 7'h79, 7'h40
  };

  logic              ones_turn;
  logic [SegW-1:0]   ones_seg;
  logic [SegW-1:0]   tens_seg;
  logic [LinesW-1:0] lines;
  disp_t             frame_q[$];

  // Drop decimal digits from the right until two remain.
  function automatic int unsigned keep_two_digits(input logic [ValueW-1:0] v);
    int unsigned n;
    n = 32'(v);
    while (n >= TWO_DIGIT_LIMIT) n = n / 10;
    return n;
  endfunction

  always @(posedge clk) begin : track
    disp_t       want;
    int unsigned n;
    if (rst) begin
      ones_turn = 1'b1;
      ones_seg  = SEG_RESET;
      tens_seg  = SEG_RESET;
      lines     = LINES_RESET;
      frame_q.delete();
      fail_cnt    = 0;
      pending_cnt <= 0;
    end else begin
      if (disp_valid && !disp_stall) begin
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected frame: segments_n=%h digit_lines=%b", $time,
                   disp.segments_n, disp.digit_lines);
          fail_cnt++;
        end else begin
          want = frame_q.pop_front();
          if (disp.segments_n !== want.segments_n) begin
            $display("%0t: segments_n mismatch: expected %h, actual %h", $time,
                     want.segments_n, disp.segments_n);
            fail_cnt++;
          end
          if (disp.digit_lines !== want.digit_lines) begin
            $display("%0t: digit_lines mismatch: expected %b, actual %b", $time,
                     want.digit_lines, disp.digit_lines);
            fail_cnt++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (item.action == ACT_WRITE) begin
          n        = keep_two_digits(item.value);
          ones_seg = DIGIT_SEG[(n % 10) * SegW +: SegW];
          tens_seg = DIGIT_SEG[(n / 10) * SegW +: SegW];
        end else begin
          lines            = ~lines;
          want.segments_n  = ones_turn ? ones_seg : tens_seg;
          want.digit_lines = lines;
          ones_turn        = !ones_turn;
          frame_q.push_back(want);
        end
      end
      pending_cnt <= frame_q.size();
    end
  end

endmodule

// File: dv/tb_two_digit_seven_segment_mux_unit.sv
`timescale 1ns / 100ps
// Testbench top for the two-digit seven-segment mux: drives writes and ticks
// with random gaps and output stalls. Depends on tdsm_pkg and tdsm_disp_checker.

module tb_two_digit_seven_segment_mux_unit;
  import tdsm_pkg::*;

  // Random items are split evenly over three idling phases.
  localparam int RandomN    = 1926;
  localparam int CycleLimit = 200000;
  // Cycles to watch for stray output once the last frames have drained.
  localparam int TailCycles = 20;

  logic  clk        = 1'b0;
  logic  rst        = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_stall;
  item_t item       = '0;
  logic  disp_valid;
  logic  disp_stall = 1'b0;
  disp_t disp;

  int fail_cnt;
  int pending_cnt;
  // Percent of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Values on either side of every divide-pass boundary, plus both extremes.
  int unsigned probe_vals [8] = '{0, 99, 100, 999, 1000, 9999, 10000, 32767};

  two_digit_seven_segment_mux_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .disp_valid (disp_valid),
    .disp_stall (disp_stall),
    .disp       (disp)
  );

  tdsm_disp_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .disp_valid  (disp_valid),
    .disp_stall  (disp_stall),
    .disp        (disp),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Display side: stall at random, redrawn every cycle.
  always @(posedge clk) begin
    disp_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one item, after a random gap, and hold it until the transfer.
  // Valid stays high from one item to the next when no gap is drawn.
  task automatic send_item(input logic act, input logic [ValueW-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item       <= {act, val};
    // item_stall read here is the value the edge just sampled.
    do @(posedge clk); while (item_stall !== 1'b0);
  endtask

  // Lower valid and hold off until every predicted frame has come out.
  // The first edge lets the checker count the last transfer.
  task automatic drain_frames();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // Ticks and writes at 55 to 45; write values spread evenly
  // over one to four divide passes so every pass count is exercised.
  task automatic send_random(input int count);
    logic [ValueW-1:0] val;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 45) begin
        case ($urandom_range(3))
          0:       val = ValueW'($urandom_range(99));
          1:       val = ValueW'($urandom_range(999, 100));
          2:       val = ValueW'($urandom_range(9999, 1000));
          default: val = ValueW'($urandom_range(32767, 10000));
        endcase
        send_item(ACT_WRITE, val);
      end else begin
        // Tick value is don't-care to the block; keep it random.
        send_item(ACT_TICK, ValueW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Ticks before any write show the reset patterns; vary the unused value.
    send_item(ACT_TICK, '1);
    send_item(ACT_TICK, '0);
    // Each probe value, then both digits of it in turn.
    for (int i = 0; i < 8; i++) begin
      send_item(ACT_WRITE, ValueW'(probe_vals[i]));
      send_item(ACT_TICK, ValueW'($urandom));
      send_item(ACT_TICK, ValueW'($urandom));
    end

    // Let the pipeline run dry once before the random traffic.
    drain_frames();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 33;
          recv_stall_pct = 53;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 33;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      send_random(RandomN / 3);
    end

    // Wait out the last frames, then watch a while for stray output.
    drain_frames();
    repeat (TailCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: end the run if the traffic never completes.
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
